>>> rtl/core/apr_pkg.sv
// ----------------------------------------------------------------------------
// apr_pkg
// Shared constants for the aging page replacement block: default sizes and
// the fixed field widths of the request and response transactions.
// ----------------------------------------------------------------------------
package apr_pkg;

   // default table geometry
   localparam int NUM_FRAMES_DEF = 8;
   localparam int AGE_BITS_DEF   = 32;

   // fixed transaction field widths
   localparam int PAGE_W        = 16;
   localparam int FRAME_IDX_W   = 3;
   localparam int MISS_W        = 32;

   // packed response data: hit, frame_index, evicted_valid, evicted_page,
   // miss_total, then zero fill up to whole bytes
   localparam int RSP_FIELDS_W  = 1 + FRAME_IDX_W + 1 + PAGE_W + MISS_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_DATA_W    = ((PAGE_W + 7) / 8) * 8;

endpackage

>>> rtl/core/apr_cell.sv
// ----------------------------------------------------------------------------
// apr_cell
// One frame of the replacement table. Holds valid, page and age, folds its
// frame into the search record passing by, and hands the registered record
// to the next cell. Applies the broadcast table update.
// ----------------------------------------------------------------------------
module apr_cell #(
   parameter int  NUM_FRAMES  = apr_pkg::NUM_FRAMES_DEF,
   parameter int  AGE_BITS    = apr_pkg::AGE_BITS_DEF,
   parameter int  IDX         = 0,
   parameter type probe_type  = logic,
   parameter type update_type = logic
) (
   input  logic       clock,
   input  logic       reset,
   input  probe_type  probe_i,
   input  update_type update_i,
   output probe_type  probe_o
);
   import apr_pkg::*;

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                valid_ff;
   logic                valid_in;
   logic [PAGE_W-1:0]   page_ff;
   logic [AGE_BITS-1:0] age_ff;
   logic [AGE_BITS-1:0] age_in;
   logic                touched;
   logic                take_min;
   probe_type           probe_ff;
   probe_type           probe_in;

   // fold this frame into the search record
   always_comb begin
      probe_in = probe_i;
      if (!probe_i.found && valid_ff && (page_ff == probe_i.page)) begin
         probe_in.found   = 1'b1;
         probe_in.hit_idx = MY_IDX;
      end
      if (!probe_i.free_found && !valid_ff) begin
         probe_in.free_found = 1'b1;
         probe_in.free_idx   = MY_IDX;
      end
      // first frame seeds the minimum, a tie moves it to the higher index
      take_min = (IDX == 0) || (age_ff <= probe_i.min_age);
      if (take_min) begin
         probe_in.min_age  = age_ff;
         probe_in.min_idx  = MY_IDX;
         probe_in.min_page = page_ff;
      end
   end

   // hand the record to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.valid <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign probe_o = probe_ff;

   // age every frame on a table update, mark the touched one
   always_comb begin
      touched  = update_i.valid && (update_i.slot == MY_IDX);
      age_in   = {touched, age_ff[AGE_BITS-1:1]};
      valid_in = valid_ff || (touched && update_i.write);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
      end else if (update_i.valid) begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
      end
   end

   // load the page on a fill or a replacement
   always_ff @(posedge clock) begin
      if (touched && update_i.write) begin
         page_ff <= update_i.page;
      end
   end

endmodule

>>> rtl/core/aging_page_replacement.sv
// ----------------------------------------------------------------------------
// Flow:    the first cell registers the search record of a request on the
//          accepting edge, each further cell registers it in turn, the tail
//          record is held, and the commit registers the response transaction.
// Requests: one at a time; a new request is taken only after the last one
//          commits, which waits on output stall, as its record walks the cells.
// Reset: synchronous, active high; empties every frame, zeroes all ages and
//          the miss count, and drops any request in flight.
// ----------------------------------------------------------------------------
// aging_page_replacement
// Aging page replacement over a table of frames built as a chain of cells.
// ----------------------------------------------------------------------------
module aging_page_replacement #(
   parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF,
   parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] page_number
   input  logic [apr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] hit, [3:1] frame_index, [4] evicted_valid, [20:5] evicted_page,
   // [52:21] miss_total, [55:53] zero
   output logic [apr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import apr_pkg::*;

   localparam int IDX_W = $clog2(NUM_FRAMES);

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [PAGE_W-1:0]   page;
      logic                found;
      logic [IDX_W-1:0]    hit_idx;
      logic                free_found;
      logic [IDX_W-1:0]    free_idx;
      logic [AGE_BITS-1:0] min_age;
      logic [IDX_W-1:0]    min_idx;
      logic [PAGE_W-1:0]   min_page;
   } probe_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  slot;
      logic              write;
      logic [PAGE_W-1:0] page;
   } update_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   probe_type                chain [NUM_FRAMES+1];
   probe_type                pend_ff;
   update_type               update;
   logic                     req_accept;
   logic                     commit;
   logic                     evict;
   logic [IDX_W-1:0]         slot;
   logic [IDX_W+2:0]         slot_ext;
   logic [MISS_W-1:0]        miss_ff;
   logic [MISS_W-1:0]        miss_in;
   logic                     rsp_valid_ff;
   logic [RSP_FIELDS_W-1:0]  rsp_data_ff;
   logic [RSP_FIELDS_W-1:0]  rsp_data_in;
   logic                     rsp_last_ff;

   // launch the search record into the chain
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      chain[0]            = '0;
      chain[0].valid      = req_accept;
      chain[0].last       = req_tlast;
      chain[0].page       = req_tdata[PAGE_W-1:0];
   end

   for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
      apr_cell #(
         .NUM_FRAMES  (NUM_FRAMES),
         .AGE_BITS    (AGE_BITS),
         .IDX         (i),
         .probe_type  (probe_type),
         .update_type (update_type)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .probe_i  (chain[i]),
         .update_i (update),
         .probe_o  (chain[i+1])
      );
   end

   // sequence one request at a time
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (chain[NUM_FRAMES].valid) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign commit     = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the record that left the tail of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff.valid <= 1'b0;
      end else if (chain[NUM_FRAMES].valid) begin
         pend_ff <= chain[NUM_FRAMES];
      end else if (commit) begin
         pend_ff.valid <= 1'b0;
      end
   end

   // pick the frame: hit, else lowest empty, else oldest
   always_comb begin
      evict = !pend_ff.found && !pend_ff.free_found;
      if (pend_ff.found) begin
         slot = pend_ff.hit_idx;
      end else if (pend_ff.free_found) begin
         slot = pend_ff.free_idx;
      end else begin
         slot = pend_ff.min_idx;
      end
      slot_ext = {3'b000, slot};

      update.valid = commit;
      update.slot  = slot;
      update.write = !pend_ff.found;
      update.page  = pend_ff.page;
   end

   // count faults, saturate at all ones
   always_comb begin
      miss_in = miss_ff;
      if (!pend_ff.found && (miss_ff != '1)) begin
         miss_in = miss_ff + MISS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff <= '0;
      end else if (commit) begin
         miss_ff <= miss_in;
      end
   end

   // register the response transaction
   assign rsp_data_in = {miss_in,
                         evict ? pend_ff.min_page : {PAGE_W{1'b0}},
                         evict,
                         slot_ext[FRAME_IDX_W-1:0],
                         pend_ff.found};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= pend_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a record only reaches the tail while a search is under way
   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_FRAMES].valid |-> (state_ff == ST_SEARCH) && !pend_ff.valid)
      else $error("search record left the chain outside a search");

   // a fault always leaves a nonzero miss count
   a_miss_nonzero: assert property (@(posedge clock) disable iff (reset)
      commit && !pend_ff.found |=> miss_ff != '0)
      else $error("miss count zero after a fault");

   // a hit leaves the miss count untouched
   a_hit_no_count: assert property (@(posedge clock) disable iff (reset)
      commit && pend_ff.found |=> miss_ff == $past(miss_ff))
      else $error("miss count changed on a hit");
`endif

endmodule
